>>> hdl/asxd_pkg.sv
// Package for the archive stream decoder: phase, role and status codes,
// configuration and result structs, keystream step function.
// No dependencies.
`timescale 1ns / 1ps

package asxd_pkg;

	localparam int unsigned APB_AW = 4;
	localparam int unsigned APB_DW = 64;

	localparam logic [31:0] MAX_NAME_LEN = 32'd255;
	localparam logic [31:0] KEY_MUL      = 32'd7;
	localparam logic [31:0] KEY_ADD      = 32'd3;

	// register index = paddr[3] (8-byte spacing)
	localparam logic REG_START_KEY  = 1'b0;
	localparam logic REG_MAGIC_WORD = 1'b1;

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_NLEN  = 3'd1,
		PH_NAME  = 3'd2,
		PH_SIZE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_STOP  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_MAGIC   = 3'd0,
		ROLE_NLEN    = 3'd1,
		ROLE_NAME    = 3'd2,
		ROLE_SIZE    = 3'd3,
		ROLE_DATA    = 3'd4,
		ROLE_IGNORED = 3'd5
	} role_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MAGIC   = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_TRUNC   = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] start_key;
		logic [63:0] magic_word;
	} cfg_t;

	typedef struct packed {
		logic [7:0] out_byte;
		role_t      byte_role;
		logic       entry_end;
		status_t    status;
	} result_t;

	function automatic logic [31:0] key_next(input logic [31:0] k);
		key_next = 32'(k * KEY_MUL + KEY_ADD);
	endfunction

endpackage

>>> hdl/asxd_if.sv
// Valid/ready stream interfaces for raw archive bytes and decoded items.
// No dependencies.
`timescale 1ns / 1ps

interface asxd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last;

	modport source (output valid, output in_byte, output last, input ready);
	modport sink   (input valid, input in_byte, input last, output ready);
endinterface

interface asxd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] byte_role;
	logic       entry_end;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_role, output entry_end,
		output status, input ready);
	modport sink   (input valid, input out_byte, input byte_role, input entry_end,
		input status, output ready);
endinterface

>>> hdl/asxd_cfg_regs.sv
// APB-style register block: start_key at 0x0, magic_word at 0x8.
// Depends on asxd_pkg.
`timescale 1ns / 1ps

module asxd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asxd_pkg::APB_AW-1:0]    paddr,
	input  logic [asxd_pkg::APB_DW-1:0]    pwdata,
	output logic [asxd_pkg::APB_DW-1:0]    prdata,
	output logic                           pready,
	output asxd_pkg::cfg_t                 cfg
);
	import asxd_pkg::*;

	logic [31:0] start_key_q;
	logic [63:0] magic_word_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_key_q  <= '0;
			magic_word_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				REG_START_KEY:  start_key_q  <= pwdata[31:0];
				REG_MAGIC_WORD: magic_word_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_START_KEY:  prdata = {32'd0, start_key_q};
			REG_MAGIC_WORD: prdata = magic_word_q;
			default:        prdata = '0;
		endcase
	end

	assign cfg.start_key  = start_key_q;
	assign cfg.magic_word = magic_word_q;

endmodule

>>> hdl/asxd_parse_core.sv
// Parser state and per-byte decode: phase tracking, header/data keys,
// word assembly and the tagged result for one byte.
// Depends on asxd_pkg.
`timescale 1ns / 1ps

module asxd_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                last,
	input  asxd_pkg::cfg_t      cfg,
	output asxd_pkg::result_t   result
);
	import asxd_pkg::*;

	phase_t      phase_q,  phase_n;
	logic [2:0]  pos_q,    pos_n;
	logic [1:0]  biw_q,    biw_n;
	logic [23:0] wa_q,     wa_n;
	logic [31:0] hkey_q,   hkey_n;
	logic [31:0] dkey_q,   dkey_n;
	logic [31:0] rem_q,    rem_n;
	status_t     stop_q,   stop_n;

	logic [7:0]  magic_byte;
	logic [7:0]  hkey_byte;
	logic [7:0]  dkey_byte;
	logic [31:0] word_val;
	logic [31:0] hkey_adv;
	logic        rem_one;

	assign magic_byte = cfg.magic_word[{pos_q, 3'b000} +: 8];
	assign hkey_byte  = hkey_q[{biw_q, 3'b000} +: 8];
	assign dkey_byte  = dkey_q[{biw_q, 3'b000} +: 8];
	assign word_val   = {in_byte, wa_q} ^ hkey_q;
	assign hkey_adv   = key_next(hkey_q);
	assign rem_one    = (rem_q == 32'd1);

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		biw_n   = biw_q;
		wa_n    = wa_q;
		hkey_n  = hkey_q;
		dkey_n  = dkey_q;
		rem_n   = rem_q;
		stop_n  = stop_q;

		result.out_byte  = in_byte;
		result.byte_role = ROLE_IGNORED;
		result.entry_end = 1'b0;
		result.status    = ST_OK;

		unique case (phase_q)
			PH_MAGIC: begin
				result.byte_role = ROLE_MAGIC;
				if (in_byte != magic_byte) begin
					stop_n        = ST_MAGIC;
					phase_n       = PH_STOP;
					pos_n         = '0;
					result.status = ST_MAGIC;
				end else if (pos_q == 3'd7) begin
					phase_n = PH_NLEN;
					pos_n   = '0;
					hkey_n  = cfg.start_key;
					biw_n   = '0;
				end else begin
					pos_n = pos_q + 3'd1;
				end
			end
			PH_NLEN, PH_SIZE: begin
				result.byte_role = (phase_q == PH_NLEN) ? ROLE_NLEN : ROLE_SIZE;
				result.out_byte  = in_byte ^ hkey_byte;
				if (biw_q != 2'd3) begin
					// lanes are overwritten in order, so no clear is needed
					wa_n[{biw_q, 3'b000} +: 8] = in_byte;
					biw_n = biw_q + 2'd1;
				end else begin
					hkey_n = hkey_adv;
					biw_n  = '0;
					if (phase_q == PH_NLEN) begin
						if (word_val == '0 || word_val > MAX_NAME_LEN) begin
							stop_n        = ST_BAD_LEN;
							phase_n       = PH_STOP;
							result.status = ST_BAD_LEN;
						end else begin
							rem_n   = word_val;
							phase_n = PH_NAME;
						end
					end else begin
						dkey_n = hkey_adv;
						if (word_val == '0) begin
							result.entry_end = 1'b1;
							phase_n          = PH_NLEN;
						end else begin
							rem_n   = word_val;
							phase_n = PH_DATA;
						end
					end
				end
			end
			PH_NAME: begin
				result.byte_role = ROLE_NAME;
				result.out_byte  = in_byte ^ hkey_q[7:0];
				hkey_n           = hkey_adv;
				rem_n            = rem_q - 32'd1;
				if (rem_one) begin
					phase_n = PH_SIZE;
					biw_n   = '0;
				end
			end
			PH_DATA: begin
				result.byte_role = ROLE_DATA;
				result.out_byte  = in_byte ^ dkey_byte;
				if (biw_q == 2'd3) begin
					dkey_n = key_next(dkey_q);
					biw_n  = '0;
				end else begin
					biw_n = biw_q + 2'd1;
				end
				rem_n = rem_q - 32'd1;
				if (rem_one) begin
					result.entry_end = 1'b1;
					phase_n          = PH_NLEN;
					biw_n            = '0;
				end
			end
			default: begin
				result.byte_role = ROLE_IGNORED;
				result.status    = stop_q;
			end
		endcase

		if (last) begin
			if (result.status == ST_OK) begin
				if (phase_n == PH_MAGIC) begin
					result.status = ST_MAGIC;
				end else if (phase_n == PH_NAME || phase_n == PH_SIZE || phase_n == PH_DATA ||
					(phase_n == PH_NLEN && biw_n != 2'd0)) begin
					result.status = ST_TRUNC;
				end
			end
			// re-arm for the next archive
			phase_n = PH_MAGIC;
			pos_n   = '0;
			biw_n   = '0;
			hkey_n  = cfg.start_key;
			dkey_n  = '0;
			rem_n   = '0;
			stop_n  = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			pos_q   <= '0;
			biw_q   <= '0;
			hkey_q  <= '0;
			dkey_q  <= '0;
			rem_q   <= '0;
			stop_q  <= ST_OK;
		end else if (step) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			biw_q   <= biw_n;
			hkey_q  <= hkey_n;
			dkey_q  <= dkey_n;
			rem_q   <= rem_n;
			stop_q  <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			wa_q <= wa_n;
		end
	end

endmodule

>>> hdl/archive_stream_xor_decrypt_parser_unit.sv
// Top level of the archive stream decoder: input register, parse core,
// result register and APB register block.
// Depends on asxd_pkg, asxd_if, asxd_cfg_regs, asxd_parse_core.
`timescale 1ns / 1ps

// Channel   Dir  Protocol      Payload
// in_ch     in   valid/ready   in_byte[7:0], last
// out_ch    out  valid/ready   out_byte[7:0], byte_role[2:0], entry_end, status[1:0]
// APB       in   psel/penable  paddr[3:0], pwdata/prdata[63:0]; 0x0 start_key, 0x8 magic_word
//
// One item per cycle sustained while out_ch accepts; an accepted item passes the input
// register and then the result register before out_ch.valid rises.
// Between the two registers sits the combinational decode (key update *7+3 and XOR).
// arst_n clears the parser to the magic phase and both valid flags; payload
// registers are not reset.
// A stalled out_ch holds its item; the input register still takes one more item,
// then in_ch.ready drops until the result is taken.

module archive_stream_xor_decrypt_parser_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	asxd_in_if.sink                        in_ch,
	asxd_out_if.source                     out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asxd_pkg::APB_AW-1:0]    paddr,
	input  logic [asxd_pkg::APB_DW-1:0]    pwdata,
	output logic [asxd_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);
	import asxd_pkg::*;

	cfg_t    cfg;
	result_t result;
	result_t result_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       advance;      // result register can take a new item
	logic       step;         // input register item is decoded this cycle
	logic       in_fire;

	asxd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance      = !out_valid_q || out_ch.ready;
	assign step         = valid_s1 && advance;
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_fire      = in_ch.valid && in_ch.ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.last;
		end
	end

	asxd_parse_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.last    (last_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_byte  = result_q.out_byte;
	assign out_ch.byte_role = 3'(result_q.byte_role);
	assign out_ch.entry_end = result_q.entry_end;
	assign out_ch.status    = 2'(result_q.status);

endmodule

>>> hdl/asxd_checker.sv
// Port-level checks on the decoder output stream, bound to the top level.
// Depends on asxd_pkg and archive_stream_xor_decrypt_parser_unit.
`timescale 1ns / 1ps

module asxd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [2:0] byte_role,
	input logic       entry_end,
	input logic [1:0] status
);
	import asxd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_role)
			&& $stable(entry_end) && $stable(status))
		else $error("output item changed while stalled");

	a_end_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && entry_end |-> byte_role == ROLE_DATA || byte_role == ROLE_SIZE)
		else $error("entry end on a byte that is not size or data");

	a_magic_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_role == ROLE_MAGIC |-> status == ST_OK || status == ST_MAGIC)
		else $error("magic byte with a non-magic status");

	a_badlen_role: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD_LEN |-> byte_role == ROLE_NLEN
			|| byte_role == ROLE_IGNORED)
		else $error("bad name length reported outside length or stopped bytes");

endmodule

bind archive_stream_xor_decrypt_parser_unit asxd_checker u_asxd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.byte_role (out_ch.byte_role),
	.entry_end (out_ch.entry_end),
	.status    (out_ch.status)
);
